// ===== rtl/kdt_pkg.sv =====
// Shared types and constants for the keyed debounce table.
package kdt_pkg;

  localparam int unsigned TABLE_ENTRIES = 32;
  localparam int unsigned IDX_W = $clog2(TABLE_ENTRIES);
  localparam int unsigned CNT_W = $clog2(TABLE_ENTRIES + 1);

  localparam int unsigned KEY_W = 64;
  localparam int unsigned TIME_W = 48;
  localparam int unsigned WIN_W = 22;

  localparam logic [1:0] ACT_SUPPRESSED = 2'd0;
  localparam logic [1:0] ACT_REFRESHED  = 2'd1;
  localparam logic [1:0] ACT_APPENDED   = 2'd2;
  localparam logic [1:0] ACT_REPLACED   = 2'd3;

  typedef struct packed {
    logic [KEY_W-1:0]  event_key;
    logic [TIME_W-1:0] now_ms;
    logic [WIN_W-1:0]  window_ms;
  } kdt_in_t;

  typedef struct packed {
    logic       suppressed;
    logic [1:0] action;
  } kdt_out_t;

  typedef struct packed {
    logic [KEY_W-1:0]  key;
    logic [TIME_W-1:0] stamp;
  } kdt_entry_t;

endpackage

// ===== rtl/keyed_debounce_table.sv =====
// Top level of the keyed debounce table: scan sequencer, entry RAM and result register.
//
// Input channel (in_valid_i / in_ready_o / in_data_i) carries one event per
// transaction: a 64-bit key, the current time and a debounce window in ms.
// Output channel (out_valid_o / out_ready_i / out_data_o) returns exactly one
// result per event: the suppression flag and the action taken.
//
// The filled entries are scanned from index 0 upward, one RAM read and one
// compare per entry, each in its own state; the idle state sets up the scan,
// and write-back (skipped on suppression) and the result load follow it. The
// scan loop through the single RAM read port dominates the time per event.
// The oldest entry is tracked during the same scan, so a full-table miss
// needs no second pass. One event is in flight at a time.
//
// Reset clears the fill count; RAM contents stay undefined and are never
// read before being written. A stalled receiver holds the result in the
// output register; the next event is accepted meanwhile and its result
// waits in the final state until the register frees.
module keyed_debounce_table (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  kdt_pkg::kdt_in_t  in_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output kdt_pkg::kdt_out_t out_data_o
);
  import kdt_pkg::*;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_RD   = 3'd1;
  localparam logic [2:0] ST_CMP  = 3'd2;
  localparam logic [2:0] ST_WR   = 3'd3;
  localparam logic [2:0] ST_DONE = 3'd4;

  logic [2:0]       state_q, state_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [IDX_W-1:0] idx_q, idx_d;
  logic [IDX_W-1:0] wr_idx_q, wr_idx_d;
  logic [IDX_W-1:0] best_idx_q, best_idx_d;
  logic [TIME_W-1:0] best_time_q, best_time_d;
  logic [1:0]       act_q, act_d;
  kdt_in_t          item_q;
  logic             out_valid_q, out_valid_d;
  kdt_out_t         out_q;
  logic             out_load;

  kdt_entry_t       rd_entry;
  kdt_entry_t       wr_entry;
  logic             ram_we;
  logic             ram_re;

  logic             key_hit;
  logic             in_window;
  logic [TIME_W-1:0] elapsed;
  logic             last_entry;
  logic             table_full;
  logic             older;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  assign ram_re   = (state_q == ST_RD);
  assign ram_we   = (state_q == ST_WR);
  assign wr_entry = '{key: item_q.event_key, stamp: item_q.now_ms};

  kdt_ram #(
    .WIDTH($bits(kdt_entry_t)),
    .DEPTH(TABLE_ENTRIES)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(wr_idx_q),
    .wdata_i(wr_entry),
    .re_i   (ram_re),
    .raddr_i(idx_q),
    .rdata_o(rd_entry)
  );

  assign key_hit    = (rd_entry.key == item_q.event_key);
  assign elapsed    = item_q.now_ms - rd_entry.stamp;
  // Time running backwards counts as inside any window.
  assign in_window  = (item_q.now_ms < rd_entry.stamp) ||
                      (elapsed < TIME_W'(item_q.window_ms));
  assign last_entry = (({1'b0, idx_q} + CNT_W'(1)) == cnt_q);
  assign table_full = (cnt_q == CNT_W'(TABLE_ENTRIES));
  // Strict compare keeps the lowest index on ties.
  assign older      = (idx_q == '0) || (rd_entry.stamp < best_time_q);

  assign out_load = (state_q == ST_DONE) && (!out_valid_q || out_ready_i);

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    idx_d       = idx_q;
    wr_idx_d    = wr_idx_q;
    best_idx_d  = best_idx_q;
    best_time_d = best_time_q;
    act_d       = act_q;
    out_valid_d = out_valid_q;

    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          idx_d = '0;
          if (cnt_q == '0) begin
            wr_idx_d = '0;
            act_d    = ACT_APPENDED;
            state_d  = ST_WR;
          end else begin
            state_d = ST_RD;
          end
        end
      end
      ST_RD: begin
        state_d = ST_CMP;
      end
      ST_CMP: begin
        if (key_hit) begin
          if (in_window) begin
            act_d   = ACT_SUPPRESSED;
            state_d = ST_DONE;
          end else begin
            act_d    = ACT_REFRESHED;
            wr_idx_d = idx_q;
            state_d  = ST_WR;
          end
        end else begin
          if (older) begin
            best_idx_d  = idx_q;
            best_time_d = rd_entry.stamp;
          end
          if (last_entry) begin
            state_d = ST_WR;
            if (table_full) begin
              act_d    = ACT_REPLACED;
              wr_idx_d = older ? idx_q : best_idx_q;
            end else begin
              act_d    = ACT_APPENDED;
              wr_idx_d = cnt_q[IDX_W-1:0];
            end
          end else begin
            idx_d   = idx_q + IDX_W'(1);
            state_d = ST_RD;
          end
        end
      end
      ST_WR: begin
        if (act_q == ACT_APPENDED) begin
          cnt_d = cnt_q + CNT_W'(1);
        end
        state_d = ST_DONE;
      end
      ST_DONE: begin
        if (out_load) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q       <= idx_d;
    wr_idx_q    <= wr_idx_d;
    best_idx_q  <= best_idx_d;
    best_time_q <= best_time_d;
    act_q       <= act_d;
    if (in_valid_i && in_ready_o) begin
      item_q <= in_data_i;
    end
    if (out_load) begin
      out_q.suppressed <= (act_q == ACT_SUPPRESSED);
      out_q.action     <= act_q;
    end
  end

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("block accepted a transaction while busy");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(TABLE_ENTRIES))
    else $error("fill count beyond table size");

  a_flag_matches_action: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.suppressed == (out_data_o.action == ACT_SUPPRESSED)))
    else $error("suppression flag disagrees with action");

  a_append_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_WR && act_q == ACT_APPENDED) |=> (cnt_q == $past(cnt_q) + CNT_W'(1)))
    else $error("append did not grow the fill count");

endmodule

// ===== rtl/kdt_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module kdt_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

// ===== sim/keyed_debounce_table_checker.sv =====
// Checker for the keyed debounce table: watches both channels, predicts results and compares.
`timescale 1ns / 100ps

module keyed_debounce_table_checker (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  input  logic                    in_ready_i,
  input  kdt_pkg::kdt_in_t        in_data_i,
  input  logic                    out_valid_i,
  input  logic                    out_ready_i,
  input  kdt_pkg::kdt_out_t       out_data_i,
  output int unsigned             errors_o,
  output int unsigned             pending_o,
  output logic [3:0][31:0]        act_seen_o
);
  import kdt_pkg::*;

  kdt_out_t          due_q[$];
  logic [KEY_W-1:0]  keys_m   [TABLE_ENTRIES];
  logic [TIME_W-1:0] stamps_m [TABLE_ENTRIES];
  int unsigned       fill_m;
  int unsigned       mismatches;
  logic [3:0][31:0]  tally;

  task automatic report_mismatch(input string what);
    $display("%0t ns: mismatch: %s", $time, what);
    mismatches++;
  endtask

  // Look up the key, update the shadow table and return the expected result.
  function automatic kdt_out_t predict_debounce(input kdt_in_t ev);
    kdt_out_t          res;
    logic              hit;
    int unsigned       slot;
    int unsigned       oldest;
    logic [TIME_W-1:0] elapsed;
    res = '0;
    hit = 1'b0;
    slot = 0;
    for (int unsigned i = 0; i < fill_m; i++) begin
      if (!hit && keys_m[i] == ev.event_key) begin
        hit = 1'b1;
        slot = i;
      end
    end
    if (hit) begin
      elapsed = ev.now_ms - stamps_m[slot];
      // time running backwards counts as inside any window
      if (ev.now_ms < stamps_m[slot] || elapsed < {{(TIME_W-WIN_W){1'b0}}, ev.window_ms}) begin
        res.suppressed = 1'b1;
        res.action = ACT_SUPPRESSED;
      end else begin
        stamps_m[slot] = ev.now_ms;
        res.action = ACT_REFRESHED;
      end
    end else if (fill_m < TABLE_ENTRIES) begin
      keys_m[fill_m] = ev.event_key;
      stamps_m[fill_m] = ev.now_ms;
      fill_m++;
      res.action = ACT_APPENDED;
    end else begin
      // evict the oldest stamp, lowest index on ties
      oldest = 0;
      for (int unsigned i = 1; i < TABLE_ENTRIES; i++)
        if (stamps_m[i] < stamps_m[oldest]) oldest = i;
      keys_m[oldest] = ev.event_key;
      stamps_m[oldest] = ev.now_ms;
      res.action = ACT_REPLACED;
    end
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    kdt_out_t want;
    if (!rst_ni) begin
      due_q.delete();
      fill_m = 0;
      mismatches = 0;
      tally = '0;
      errors_o <= 0;
      pending_o <= 0;
      act_seen_o <= '0;
    end else begin
      // retire the oldest expectation before queuing a new one
      if (out_valid_i && out_ready_i) begin
        if (due_q.size() == 0) begin
          report_mismatch($sformatf("result with nothing pending (suppressed %0b action %0d)",
                                    out_data_i.suppressed, out_data_i.action));
        end else begin
          want = due_q.pop_front();
          tally[want.action] = tally[want.action] + 1;
          if (out_data_i.suppressed !== want.suppressed)
            report_mismatch($sformatf("suppressed got %b expected %b",
                                      out_data_i.suppressed, want.suppressed));
          if (out_data_i.action !== want.action)
            report_mismatch($sformatf("action got %0d expected %0d",
                                      out_data_i.action, want.action));
        end
      end
      if (in_valid_i && in_ready_i) due_q.push_back(predict_debounce(in_data_i));
      errors_o <= mismatches;
      pending_o <= due_q.size();
      act_seen_o <= tally;
    end
  end

endmodule

// ===== sim/keyed_debounce_table_test.sv =====
// Stimulus and verdict for the keyed debounce table, with the checker alongside.
`timescale 1ns / 100ps

module keyed_debounce_table_test;
  import kdt_pkg::*;

  localparam int unsigned RANDOM_EVENTS = 1380;
  localparam int unsigned CALM_TAIL     = 150;
  localparam int unsigned KEY_POOL      = 40;
  localparam int unsigned DRAIN_CYCLES  = 100;
  localparam int unsigned STALL_LIMIT   = 2000;

  logic        clk_i;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  kdt_in_t     in_data_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  kdt_out_t    out_data_o;

  int unsigned      errors;
  int unsigned      pending;
  logic [3:0][31:0] act_seen;
  int unsigned      idle_odds = 4;
  int unsigned      sent;
  int unsigned      hold_cycles = 0;
  int unsigned      quiet_cycles = 0;
  logic [KEY_W-1:0] key_pool [KEY_POOL];

  keyed_debounce_table dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  keyed_debounce_table_checker checker_i (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_i  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_i (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_i  (out_data_o),
    .errors_o    (errors),
    .pending_o   (pending),
    .act_seen_o  (act_seen)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // Receiver: stall in bursts while idling is enabled.
  always @(posedge clk_i) begin
    if (hold_cycles != 0) begin
      hold_cycles--;
      out_ready_i <= 1'b0;
    end else if (idle_odds != 0 && $urandom_range(1, idle_odds) == 1) begin
      hold_cycles = $urandom_range(1, 11) - 1;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("Timeout: no transaction for %0d cycles", STALL_LIMIT);
      $display("Regression FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Present one event and hold it until the transaction completes.
  task automatic send_event(input logic [KEY_W-1:0] key, input logic [TIME_W-1:0] stamp,
                            input logic [WIN_W-1:0] win);
    if (idle_odds != 0 && $urandom_range(1, idle_odds) == 1) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i <= '{event_key: key, now_ms: stamp, window_ms: win};
    do @(posedge clk_i); while (!in_ready_o);
    sent++;
  endtask

  initial begin
    logic [TIME_W-1:0] clock_ms;
    logic [TIME_W-1:0] stamp;
    logic [KEY_W-1:0]  key;
    logic [KEY_W-1:0]  last_key;
    logic [WIN_W-1:0]  win;
    int unsigned       pick;
    sent = 0;
    for (int i = 0; i < KEY_POOL; i++) key_pool[i] = {$urandom, $urandom};
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: window edges, backwards time, zero window, field extremes
    send_event('0, '0, 22'd100);
    send_event('0, 48'd50, 22'd100);
    send_event('0, 48'd100, 22'd100);
    send_event('0, 48'd10, 22'd100);
    send_event('1, '1, '1);
    send_event('1, '1, '0);
    send_event('1, '0, '0);
    send_event({32{2'b10}}, {24{2'b01}}, 22'd3600000);
    send_event({32{2'b10}}, {24{2'b01}} + 48'd3599999, 22'd3600000);
    send_event({32{2'b10}}, {24{2'b01}} + 48'd3600000, 22'd3600000);
    send_event({32{2'b01}}, {24{2'b10}}, {11{2'b10}});
    send_event({32{2'b01}}, {24{2'b10}}, {11{2'b01}});
    send_event(64'h8000_0000_0000_0000, 48'h8000_0000_0000, 22'h20_0000);
    send_event(64'h1, 48'h1, 22'd1);
    send_event(64'h1, 48'h1, 22'd1);
    send_event(64'h1, 48'h2, 22'd1);
    send_event(64'h1, 48'h0, 22'd1);

    clock_ms = TIME_W'({$urandom, $urandom} >> 20);
    last_key = key_pool[0];
    for (int n = 0; n < RANDOM_EVENTS; n++) begin
      if (n >= RANDOM_EVENTS - CALM_TAIL) begin
        idle_odds = 0;
      end else begin
        case ((n / 100) % 3)
          0: idle_odds = 4;
          1: idle_odds = 0;
          default: idle_odds = 12;
        endcase
      end

      // mostly recurring keys so hits, refreshes and evictions all occur
      pick = $urandom_range(0, 99);
      if (pick < 30) key = last_key;
      else if (pick < 85) key = key_pool[$urandom_range(0, KEY_POOL - 1)];
      else key = {$urandom, $urandom};
      if ($urandom_range(0, 49) == 0)
        key_pool[$urandom_range(0, KEY_POOL - 1)] = {$urandom, $urandom};
      last_key = key;

      pick = $urandom_range(0, 99);
      if (pick < 6) begin
        clock_ms = TIME_W'({$urandom, $urandom});
        stamp = clock_ms;
      end else if (pick < 12) begin
        stamp = clock_ms - TIME_W'($urandom_range(1, 5000));
      end else begin
        clock_ms = clock_ms + TIME_W'($urandom_range(0, 2500));
        stamp = clock_ms;
      end

      pick = $urandom_range(0, 99);
      if (pick < 5) win = '0;
      else if (pick < 10) win = WIN_W'($urandom);
      else if (pick < 13) win = 22'd100;
      else if (pick < 15) win = 22'd3600000;
      else win = WIN_W'($urandom_range(100, 4000));

      send_event(key, stamp, win);
    end
    in_valid_i <= 1'b0;

    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Sent %0d events; results: %0d suppressed, %0d refreshed, %0d appended, %0d evicted",
             sent, act_seen[ACT_SUPPRESSED], act_seen[ACT_REFRESHED],
             act_seen[ACT_APPENDED], act_seen[ACT_REPLACED]);
    $display("Mismatches: %0d, results still outstanding: %0d", errors, pending);
    if (errors == 0 && pending == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
